FILE: rtl/core/mfs_pkg.sv
package mfs_pkg;

    // JPEG marker bytes
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;

    localparam int LEN_W   = 21;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'b1;

    localparam logic [LEN_W-1:0] FRAME_LIMIT_RST = 21'd65536;

    // result queue depth, at least 3
    localparam int QDEPTH_DEF = 4;

    // splitter phase codes
    localparam logic [1:0] PH_HUNT     = 2'd0;
    localparam logic [1:0] PH_HUNT_FF  = 2'd1;
    localparam logic [1:0] PH_FRAME    = 2'd2;
    localparam logic [1:0] PH_FRAME_FF = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             frame_last;
        logic             frame_good;
        logic [CNT_W-1:0] frame_number;
        logic             end_of_video;
    } t_out_word;

    // queue write control
    typedef struct packed {
        logic push0;
        logic push1;
    } t_qctl;

endpackage

FILE: rtl/core/mfs_outq.sv
module mfs_outq #(
    parameter int QDEPTH = mfs_pkg::QDEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mfs_pkg::t_qctl    i_ctl,
    input  mfs_pkg::t_out_word i_word0,
    input  mfs_pkg::t_out_word i_word1,
    input  logic              i_pop,
    output logic              o_valid,
    output mfs_pkg::t_out_word o_head,
    output logic              o_room2
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM2_MAX = CNT_W'(QDEPTH - 2);

    mfs_pkg::t_out_word r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd, wr1;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr1 = ptr_inc(r_wr);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr = r_wr;
        if (i_ctl.push0 && i_ctl.push1) begin
            n_wr = ptr_inc(wr1);
        end else if (i_ctl.push0) begin
            n_wr = wr1;
        end
        n_rd  = i_pop ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt + CNT_W'(i_ctl.push0) + CNT_W'(i_ctl.push0 & i_ctl.push1)
                - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, two words written per cycle at most
    always_ff @(posedge i_clk) begin
        if (i_ctl.push0) begin
            r_mem[r_wr] <= i_word0;
        end
        if (i_ctl.push0 && i_ctl.push1) begin
            r_mem[wr1] <= i_word1;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room2 = (r_cnt <= ROOM2_MAX);

endmodule

FILE: rtl/core/mjpeg_frame_splitter.sv
// channel | dir | handshake                  | payload
// --------+-----+----------------------------+------------------------------
// in      | in  | i_valid / o_ready          | i_data  (t_in_word)
// out     | out | o_valid / i_ready          | o_data  (t_out_word)
// cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One input word per cycle while o_ready is high; each accepted word is
// parsed in its accept cycle and its zero, one or two result words go into
// a small result queue, whose registered head drives o_data. One result
// word leaves per cycle from the queue head while i_ready is high.
// o_ready drops only while the queue lacks room for two words (stall on out).
// Synchronous active-low reset clears phase, length, counter and config.
module mjpeg_frame_splitter #(
    parameter int QDEPTH = mfs_pkg::QDEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  mfs_pkg::t_in_word                i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output mfs_pkg::t_out_word               o_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfs_pkg::LEN_W-1:0]        i_cfg_data
);

    localparam int LW = mfs_pkg::LEN_W;
    localparam int CW = mfs_pkg::CNT_W;

    logic            r_loop;
    logic [LW-1:0]   r_limit;
    logic [1:0]      r_phase, n_phase;
    logic [LW-1:0]   r_len, n_len;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic            accept, room2;
    mfs_pkg::t_qctl  qctl;
    mfs_pkg::t_out_word word0, word1;

    logic [LW-1:0]   len_inc;
    logic [CW-1:0]   cnt_inc;
    logic            lim_hit, lim_hit_soi;

    assign accept      = i_valid & o_ready;
    assign o_ready     = room2;
    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop  <= 1'b0;
            r_limit <= mfs_pkg::FRAME_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfs_pkg::CFG_LOOP_ENABLE: r_loop  <= i_cfg_data[0];
                mfs_pkg::CFG_FRAME_LIMIT: r_limit <= i_cfg_data;
            endcase
        end
    end

    // size-limit compares: length after this byte, plus one, against limit
    assign len_inc     = r_len + LW'(1);
    assign cnt_inc     = r_cnt + CW'(1);
    assign lim_hit     = ({1'b0, len_inc} + (LW+1)'(1)) >= {1'b0, r_limit};
    assign lim_hit_soi = (LW+1)'(3) >= {1'b0, r_limit};

    // parser: next state and result words
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        qctl    = '0;
        word0   = '0;
        word1   = '0;
        word0.frame_number = r_cnt;
        word1.frame_number = r_cnt;

        if (i_data.end_of_input) begin
            qctl.push0 = 1'b1;
            n_phase    = mfs_pkg::PH_HUNT;
            n_len      = '0;
            if (r_phase == mfs_pkg::PH_HUNT || r_phase == mfs_pkg::PH_HUNT_FF) begin
                // end of video while hunting
                if (r_loop) begin
                    n_cnt = '0;
                end
                word0.frame_number = r_loop ? '0 : r_cnt;
                word0.end_of_video = 1'b1;
            end else begin
                // end of input closes the open frame
                n_cnt              = cnt_inc;
                word0.frame_last   = 1'b1;
                word0.frame_good   = (r_len > LW'(2));
                word0.frame_number = cnt_inc;
            end
        end else begin
            unique case (r_phase)
                mfs_pkg::PH_HUNT: begin
                    if (i_data.data_byte == mfs_pkg::BYTE_FF) begin
                        n_phase = mfs_pkg::PH_HUNT_FF;
                    end
                end
                mfs_pkg::PH_HUNT_FF: begin
                    if (i_data.data_byte != mfs_pkg::BYTE_SOI) begin
                        n_phase = mfs_pkg::PH_HUNT;
                    end else begin
                        // frame start: emit FF then D8
                        qctl.push0       = 1'b1;
                        qctl.push1       = 1'b1;
                        word0.out_byte   = mfs_pkg::BYTE_FF;
                        word0.byte_valid = 1'b1;
                        word1.out_byte   = mfs_pkg::BYTE_SOI;
                        word1.byte_valid = 1'b1;
                        if (lim_hit_soi) begin
                            n_phase            = mfs_pkg::PH_HUNT;
                            n_len              = '0;
                            n_cnt              = cnt_inc;
                            word1.frame_last   = 1'b1;
                            word1.frame_number = cnt_inc;
                        end else begin
                            n_phase = mfs_pkg::PH_FRAME;
                            n_len   = LW'(2);
                        end
                    end
                end
                mfs_pkg::PH_FRAME, mfs_pkg::PH_FRAME_FF: begin
                    qctl.push0       = 1'b1;
                    word0.out_byte   = i_data.data_byte;
                    word0.byte_valid = 1'b1;
                    if (r_phase == mfs_pkg::PH_FRAME &&
                        i_data.data_byte == mfs_pkg::BYTE_FF) begin
                        // marker prefix, no limit check
                        n_len   = len_inc;
                        n_phase = mfs_pkg::PH_FRAME_FF;
                    end else if ((r_phase == mfs_pkg::PH_FRAME_FF &&
                                  i_data.data_byte == mfs_pkg::BYTE_EOI) || lim_hit) begin
                        // end marker or buffer full
                        n_phase            = mfs_pkg::PH_HUNT;
                        n_len              = '0;
                        n_cnt              = cnt_inc;
                        word0.frame_last   = 1'b1;
                        word0.frame_good   = (len_inc > LW'(2));
                        word0.frame_number = cnt_inc;
                    end else begin
                        n_len   = len_inc;
                        n_phase = mfs_pkg::PH_FRAME;
                    end
                end
            endcase
        end

        if (!accept) begin
            qctl    = '0;
            n_phase = r_phase;
            n_len   = r_len;
            n_cnt   = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mfs_pkg::PH_HUNT;
            r_len   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

    // result queue
    mfs_outq #(
        .QDEPTH (QDEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_word0 (word0),
        .i_word1 (word1),
        .i_pop   (o_valid & i_ready),
        .o_valid (o_valid),
        .o_head  (o_data),
        .o_room2 (room2)
    );

    // an accepted end of input always yields a result next cycle
    a_eoi_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.end_of_input) |=> o_valid)
        else $error("end of input produced no result");

    // a closing word is never an end-of-video word
    a_last_not_eov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.frame_last) |-> !o_data.end_of_video)
        else $error("frame_last together with end_of_video");

    // end-of-video words carry no byte
    a_eov_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.end_of_video) |-> !o_data.byte_valid)
        else $error("end_of_video word carries a byte");

    // input stalls only while results are pending
    a_stall_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty result queue");

endmodule
